FILE: rtl/mf3_pkg.sv
// shared types and constants for the 3x3 median image filter
// used by the stream interfaces and every module of the filter
package mf3_pkg;

    localparam int PIX_W     = 16;
    localparam int REG_W     = 13;
    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 13;
    localparam int OUT_ROW_W = 12;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [REG_W-1:0]  reg_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic              cfg_idx_t;

    // window row-major, row 0 is the oldest line
    typedef pix_t [8:0] win9_t;

    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam reg_t WIDTH_RESET  = REG_W'(640);
    localparam reg_t HEIGHT_RESET = REG_W'(480);
    localparam reg_t WIDTH_MIN    = REG_W'(16);
    localparam reg_t WIDTH_MAX    = REG_W'(MAX_WIDTH);
    localparam reg_t HEIGHT_MIN   = REG_W'(1);
    localparam reg_t HEIGHT_MAX   = REG_W'(4096);

    // border and framing flags of one result
    typedef struct packed {
        logic emit;
        logic top;
        logic bot;
        logic lft;
        logic rgt;
        logic last;
    } win_ctl_t;

    typedef struct packed {
        logic     process;
        logic     drain;
        addr_t    addr;
        win_ctl_t win;
    } item_ctl_t;

endpackage

FILE: rtl/mf3_ifs.sv
// valid/ready stream interfaces for pixel input and median output
// depends on mf3_pkg
interface mf3_pix_if;
    import mf3_pkg::*;
    logic valid;
    logic ready;
    logic operation;
    pix_t pixel_value;
    modport source (output valid, operation, pixel_value, input ready);
    modport sink   (input valid, operation, pixel_value, output ready);
endinterface

interface mf3_med_if;
    import mf3_pkg::*;
    logic valid;
    logic ready;
    pix_t median_value;
    logic frame_last;
    modport source (output valid, median_value, frame_last, input ready);
    modport sink   (input valid, median_value, frame_last, output ready);
endinterface

FILE: rtl/mf3_ctrl.sv
// configuration registers and raster position counters of the median filter
// decides per beat whether the item is used, and its border flags; uses mf3_pkg
module mf3_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  mf3_pkg::cfg_idx_t   cfg_index,
    input  mf3_pkg::reg_t       cfg_data,
    input  logic                beat,
    input  logic                operation,
    output mf3_pkg::item_ctl_t  ctl
);
    import mf3_pkg::*;

    reg_t                 width_reg, width_next;
    reg_t                 height_reg, height_next;
    addr_t                in_col_reg, in_col_next;
    logic [ROW_W-1:0]     in_row_reg, in_row_next;
    addr_t                out_col_reg, out_col_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;

    reg_t                 eff_w, eff_h, w_m1, h_m1;
    addr_t                w_last;
    logic [OUT_ROW_W-1:0] h_last;
    logic                 all_in, pending;

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            eff_w = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            eff_w = WIDTH_MAX;
        else
            eff_w = width_reg;
        if (height_reg < HEIGHT_MIN)
            eff_h = HEIGHT_MIN;
        else if (height_reg > HEIGHT_MAX)
            eff_h = HEIGHT_MAX;
        else
            eff_h = height_reg;
    end

    assign w_m1   = eff_w - REG_W'(1);
    assign h_m1   = eff_h - REG_W'(1);
    assign w_last = w_m1[ADDR_W-1:0];
    assign h_last = h_m1[OUT_ROW_W-1:0];

    assign all_in  = in_row_reg >= eff_h;
    assign pending = {1'b0, out_row_reg} < eff_h;

    // once the frame's pixels are all in, any beat pushes the last rows out
    assign ctl.process  = all_in ? pending : (operation == OP_PIXEL);
    assign ctl.drain    = all_in;
    assign ctl.addr     = in_col_reg;
    assign ctl.win.emit = (in_row_reg > ROW_W'(1))
                          || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
    assign ctl.win.top  = out_row_reg == '0;
    assign ctl.win.bot  = out_row_reg == h_last;
    assign ctl.win.lft  = out_col_reg == '0;
    assign ctl.win.rgt  = out_col_reg == w_last;
    assign ctl.win.last = ctl.win.bot && ctl.win.rgt;

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (beat && ctl.process)
        begin
            if (ctl.win.emit)
            begin
                if (ctl.win.rgt)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OUT_ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + ADDR_W'(1);
                end
            end
            if (ctl.win.emit && ctl.win.last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (in_col_reg == w_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

FILE: rtl/mf3_line_store.sv
// two line memories holding the two rows above the incoming pixel
// registered read at the beat, write-back one stage later; uses mf3_pkg
module mf3_line_store (
    input  logic           clk,
    input  logic           rd_en,
    input  mf3_pkg::addr_t rd_addr,
    output mf3_pkg::pix_t  up_data,
    output mf3_pkg::pix_t  mid_data,
    input  logic           wr_en,
    input  mf3_pkg::addr_t wr_addr,
    input  mf3_pkg::pix_t  wr_up,
    input  mf3_pkg::pix_t  wr_mid
);
    import mf3_pkg::*;

    pix_t upper_mem  [0:MAX_WIDTH-1];
    pix_t middle_mem [0:MAX_WIDTH-1];
    pix_t up_q_reg, mid_q_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_q_reg  <= upper_mem[rd_addr];
            mid_q_reg <= middle_mem[rd_addr];
        end
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_up;
            middle_mem[wr_addr] <= wr_mid;
        end
    end

    assign up_data  = up_q_reg;
    assign mid_data = mid_q_reg;

endmodule

FILE: rtl/mf3_median.sv
// three-stage median-of-nine: row sorts, column reduce, final median of three
// drives the result stream from its output register; uses mf3_pkg
module mf3_median (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mf3_pkg::win9_t   win,
    input  logic             in_last,
    mf3_med_if.source        med_out
);
    import mf3_pkg::*;

    typedef pix_t [2:0] trio_t;

    // returns {hi, mid, lo}
    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t lo0, hi0, md0;
        trio_t r;
        lo0  = (a < b) ? a : b;
        hi0  = (a < b) ? b : a;
        md0  = (hi0 < c) ? hi0 : c;
        r[2] = (hi0 < c) ? c : hi0;
        r[0] = (lo0 < md0) ? lo0 : md0;
        r[1] = (lo0 < md0) ? md0 : lo0;
        return r;
    endfunction

    logic  a_valid_reg;
    trio_t a_row_reg [0:2];
    logic  a_last_reg;
    logic  b_valid_reg;
    pix_t  b_x_reg, b_y_reg, b_z_reg;
    logic  b_last_reg;
    logic  o_valid_reg;
    pix_t  o_median_reg;
    logic  o_last_reg;

    logic  o_go, b_go, a_go;
    trio_t lo_s, md_s, hi_s, fin_s;

    assign o_go     = !o_valid_reg || med_out.ready;
    assign b_go     = !b_valid_reg || o_go;
    assign a_go     = !a_valid_reg || b_go;
    assign in_ready = a_go;

    // largest low, median of mids, smallest high
    assign lo_s  = sort3(a_row_reg[0][0], a_row_reg[1][0], a_row_reg[2][0]);
    assign md_s  = sort3(a_row_reg[0][1], a_row_reg[1][1], a_row_reg[2][1]);
    assign hi_s  = sort3(a_row_reg[0][2], a_row_reg[1][2], a_row_reg[2][2]);
    assign fin_s = sort3(b_x_reg, b_y_reg, b_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_go)
                a_valid_reg <= in_valid;
            if (b_go)
                b_valid_reg <= a_valid_reg;
            if (o_go)
                o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go && in_valid)
        begin
            for (int r = 0; r < 3; r++)
                a_row_reg[r] <= sort3(win[3*r], win[3*r+1], win[3*r+2]);
            a_last_reg <= in_last;
        end
        if (b_go && a_valid_reg)
        begin
            b_x_reg    <= lo_s[2];
            b_y_reg    <= md_s[1];
            b_z_reg    <= hi_s[0];
            b_last_reg <= a_last_reg;
        end
        if (o_go && b_valid_reg)
        begin
            o_median_reg <= fin_s[1];
            o_last_reg   <= b_last_reg;
        end
    end

    assign med_out.valid        = o_valid_reg;
    assign med_out.median_value = o_median_reg;
    assign med_out.frame_last   = o_last_reg;

endmodule

FILE: rtl/median_3x3_image_filter_core.sv
// top level of the 3x3 median image filter: counters, line stores, window, median
// depends on mf3_pkg, mf3_ifs, mf3_ctrl, mf3_line_store and mf3_median
//
// One item is taken per clock unless the median pipeline holds the window stage.
// Pixels arrive in raster order; the result for a pixel leaves once its 3x3 window
// is complete, i.e. one row and one pixel later, and the last row and one pixel of
// a frame are pushed out by drain beats. Out-of-frame neighbours repeat the nearest
// edge pixel. A result goes from the window stage through the median's row-sort,
// column and output registers. The line stores keep up: each line memory is read at
// the input beat and written back as the window stage advances, on a read port and
// a write port of its own. Writing image_width or image_height restarts the frame;
// widths below 16 act as 16, heights of 0 act as 1, larger values saturate at 4096.
module median_3x3_image_filter_core (
    input  logic                clk,
    input  logic                rst_n,
    mf3_pix_if.sink             pix_in,
    mf3_med_if.source           med_out,
    input  logic                cfg_we,
    input  mf3_pkg::cfg_idx_t   cfg_index,
    input  mf3_pkg::reg_t       cfg_data
);
    import mf3_pkg::*;

    item_ctl_t ctl;
    logic      in_beat, load, advance, s1_go, med_ready, med_valid;
    pix_t      up_q, mid_q;

    logic      s1_valid_reg;
    pix_t      s1_px_reg;
    addr_t     s1_addr_reg;
    win_ctl_t  s1_ctl_reg;

    pix_t      win_reg  [0:2][0:2];
    pix_t      win_next [0:2][0:2];
    win9_t     med_win;

    assign in_beat = pix_in.valid && pix_in.ready;
    assign load    = in_beat && ctl.process;

    mf3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat      (in_beat),
        .operation (pix_in.operation),
        .ctl       (ctl)
    );

    assign s1_go        = !s1_ctl_reg.emit || med_ready;
    assign advance      = s1_valid_reg && s1_go;
    assign pix_in.ready = !s1_valid_reg || s1_go;

    mf3_line_store u_lines (
        .clk      (clk),
        .rd_en    (load),
        .rd_addr  (ctl.addr),
        .up_data  (up_q),
        .mid_data (mid_q),
        .wr_en    (advance),
        .wr_addr  (s1_addr_reg),
        .wr_up    (mid_q),
        .wr_mid   (s1_px_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_px_reg   <= ctl.drain ? '0 : pix_in.pixel_value;
            s1_addr_reg <= ctl.addr;
            s1_ctl_reg  <= ctl.win;
        end
    end

    // window after the shift: new column on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_q;
        win_next[1][2] = mid_q;
        win_next[2][2] = s1_px_reg;
    end

    // edge replication: border rows and columns take the center line
    always_comb
    begin
        int ri, cj;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ri = r;
                cj = c;
                if ((r == 0 && s1_ctl_reg.top) || (r == 2 && s1_ctl_reg.bot))
                    ri = 1;
                if ((c == 0 && s1_ctl_reg.lft) || (c == 2 && s1_ctl_reg.rgt))
                    cj = 1;
                med_win[3*r+c] = win_next[ri][cj];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (advance)
        begin
            win_reg <= win_next;
        end
    end

    assign med_valid = s1_valid_reg && s1_ctl_reg.emit;

    mf3_median u_median (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (med_valid),
        .in_ready (med_ready),
        .win      (med_win),
        .in_last  (s1_ctl_reg.last),
        .med_out  (med_out)
    );

    // a line read only meets its own pending write-back right after a restart
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (load && advance && ctl.addr == s1_addr_reg) |-> !ctl.win.emit)
        else $error("line store read collides with write-back on a live row");

    // the frame's last result sends the counters back to the frame start
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && ctl.win.emit && ctl.win.last) |=> (ctl.addr == '0 && !ctl.win.emit))
        else $error("counters not back at frame start after last result");

    // a window stage holding a result waits for the median pipeline
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("window stage lost a beat while stalled");

endmodule
